### design/vfsd_pkg.sv
// ----------------------------------------------------------------------------
// vfsd_pkg
// Shared types and constants of the V/f three-phase sine duty generator:
// phase and cosine widths, polynomial coefficients, register indexes,
// sequencer states and the bundles passed between the modules.
// ----------------------------------------------------------------------------
package vfsd_pkg;

  localparam int PHASE_BITS     = 32;
  localparam int COS_TABLE_BITS = 10;

  localparam int PHASE_SHIFT = 32 - PHASE_BITS;
  localparam logic [31:0] COS_MASK =
      ~((32'd1 << (32 - COS_TABLE_BITS)) - 32'd1);

  localparam logic [31:0] THIRD_TURN   = 32'd1431655765;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [30:0] Q30_ONE      = 31'h4000_0000;

  // odd sine polynomial, Horner form, evaluated in x^2
  localparam logic [30:0] HORNER_SEED = 31'd172272;

  function automatic logic [30:0] horner_coef(input logic [1:0] k);
    logic [30:0] c;
    unique case (k)
      2'd0: c = 31'd5026994;
      2'd1: c = 31'd85569306;
      2'd2: c = 31'd693598668;
      2'd3: c = 31'd1686629713;
    endcase
    return c;
  endfunction

  localparam logic [1:0] REG_TARGET_INC = 2'd0;
  localparam logic [1:0] REG_RAMP_STEP  = 2'd1;
  localparam logic [1:0] REG_VF_SLOPE   = 2'd2;
  localparam logic [1:0] REG_VF_OFFSET  = 2'd3;

  localparam logic [1:0] ANG_A = 2'd0;
  localparam logic [1:0] ANG_B = 2'd1;
  localparam logic [1:0] ANG_C = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RAMP,
    S_CLAMP,
    S_PHASE,
    S_AMP,
    S_ANGLE,
    S_FOLD,
    S_SQ,
    S_X2,
    S_HMUL,
    S_HSUB,
    S_FMUL,
    S_COS,
    S_DMUL,
    S_DUTY,
    S_DONE
  } vfsd_state_t;

  typedef struct packed {
    logic [31:0] target_increment;
    logic [30:0] ramp_step;
    logic [31:0] vf_slope;
    logic [15:0] vf_offset;
  } vfsd_cfg_t;

  typedef struct packed {
    logic [15:0] duty_a;
    logic [15:0] duty_b;
    logic [15:0] duty_c;
    logic [15:0] phase_angle;
    logic        ramping;
  } vfsd_result_t;

endpackage

### design/vf_three_phase_sine_duty_generator.sv
// ----------------------------------------------------------------------------
// vf_three_phase_sine_duty_generator
// Open-loop V/f three-phase sine PWM duty generator, one result per tick.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration: cfg_we writes cfg_wdata into register cfg_index (0 target
//   increment, 1 ramp step, 2 V/f slope, 3 V/f offset). Write only while no
//   tick is in flight.
//   Input: one transaction per control tick on in_valid/in_stall carrying
//   in_output_enable. Output: one transaction per tick with three duties,
//   the phase angle and the ramping flag.
//   Sequencing: an enabled tick steps through one shared multiplier: ramp,
//   phase, amplitude, then the three cosine/duty evaluations in turn; the
//   result is then held in the sequencer until the output register takes it,
//   and the next tick is taken once the sequencer is back in idle. A disabled
//   tick skips the sequence and returns zero duties.
//   in_stall is high while the sequencer works. The result sits in an output
//   register, so a new tick is taken while an earlier result waits; a stalled
//   receiver holds the finished result in the sequencer until it drains.
//   Reset clears the config registers, out_valid, phase and current increment.
// ----------------------------------------------------------------------------
module vf_three_phase_sine_duty_generator import vfsd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_output_enable,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_duty_a,
  output logic [15:0] out_duty_b,
  output logic [15:0] out_duty_c,
  output logic [15:0] out_phase_angle,
  output logic        out_ramping
);

  vfsd_cfg_t    cfg_r, cfg_nxt;
  vfsd_result_t core_res;
  vfsd_result_t out_r, out_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic         core_idle, core_done, core_ack, start;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_TARGET_INC: cfg_nxt.target_increment = cfg_wdata;
        REG_RAMP_STEP:  cfg_nxt.ramp_step        = cfg_wdata[30:0];
        REG_VF_SLOPE:   cfg_nxt.vf_slope         = cfg_wdata;
        REG_VF_OFFSET:  cfg_nxt.vf_offset        = cfg_wdata[15:0];
      endcase
    end
  end

  assign in_stall = !core_idle;
  assign start    = in_valid && core_idle;
  assign core_ack = core_done && (!out_valid_r || !out_stall);

  vfsd_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .start_en(in_output_enable),
    .cfg     (cfg_r),
    .ack     (core_ack),
    .idle    (core_idle),
    .done    (core_done),
    .res     (core_res)
  );

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (core_ack) begin
      out_nxt       = core_res;
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_duty_a      = out_r.duty_a;
  assign out_duty_b      = out_r.duty_b;
  assign out_duty_c      = out_r.duty_c;
  assign out_phase_angle = out_r.phase_angle;
  assign out_ramping     = out_r.ramping;

endmodule

### design/vfsd_mul.sv
// ----------------------------------------------------------------------------
// vfsd_mul
// Shared signed multiplier with a registered product. Operands are 33-bit
// signed so that both 32-bit signed and 31-bit unsigned values fit.
// ----------------------------------------------------------------------------
module vfsd_mul import vfsd_pkg::*; (
  input  logic               clk,
  input  logic signed [32:0] mul_a,
  input  logic signed [32:0] mul_b,
  output logic signed [63:0] prod_r
);

  logic signed [65:0] prod_full;

  // operands never both reach -2^32, so 64 bits hold every product used
  assign prod_full = mul_a * mul_b;

  always_ff @(posedge clk) begin
    prod_r <= $signed(prod_full[63:0]);
  end

endmodule

### design/vfsd_core.sv
// ----------------------------------------------------------------------------
// vfsd_core
// Sequencer and datapath: ramps the increment, advances the phase, forms the
// V/f amplitude and evaluates three cosines and duties, all products on one
// shared multiplier. Holds the frequency and phase state.
// ----------------------------------------------------------------------------
module vfsd_core import vfsd_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic         start_en,
  input  vfsd_cfg_t    cfg,
  input  logic         ack,
  output logic         idle,
  output logic         done,
  output vfsd_result_t res
);

  vfsd_state_t state_r, state_nxt;

  logic signed [31:0] cur_r, cur_nxt;
  logic [PHASE_BITS-1:0] acc_r, acc_nxt;
  logic signed [32:0] sum_r, sum_nxt;
  logic               jump_r, jump_nxt;
  logic               up_r, up_nxt;
  logic signed [15:0] amp_r, amp_nxt;
  logic [1:0]         ang_r, ang_nxt;
  logic [1:0]         k_r, k_nxt;
  logic [31:0]        angw_r, angw_nxt;
  logic [1:0]         quad_r, quad_nxt;
  logic [30:0]        x_r, x_nxt;
  logic [30:0]        x2_r, x2_nxt;
  logic [30:0]        p_r, p_nxt;
  logic signed [16:0] cos_r, cos_nxt;
  vfsd_result_t       res_r, res_nxt;

  logic signed [32:0] mul_a, mul_b;
  logic signed [63:0] prod_r;

  logic signed [31:0] tgt;
  logic signed [32:0] tgt33, cur33, step33;
  logic [31:0]        turn, turn_sum, s_word;
  logic signed [33:0] amp_sum;
  logic [31:0]        r_sum;
  logic [16:0]        r_mag;
  logic signed [33:0] duty_t;
  logic [15:0]        duty_v;

  vfsd_mul u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .prod_r(prod_r)
  );

  assign tgt    = $signed(cfg.target_increment);
  assign tgt33  = 33'(tgt);
  assign cur33  = 33'(cur_r);
  assign step33 = $signed({2'b00, cfg.ramp_step});

  assign turn     = 32'(acc_r) << PHASE_SHIFT;
  assign turn_sum = turn + cur_r;

  // amplitude: offset + floor(slope*cur / 2^31)
  assign amp_sum = 34'(signed'(cfg.vf_offset)) + 34'($signed(prod_r[63:31]));

  // cosine magnitude rounded to Q1.15
  assign r_sum = 32'(prod_r[60:30]) + 32'd16384;
  assign r_mag = (r_sum[31:15] > 17'd32768) ? 17'd32768 : r_sum[31:15];

  assign s_word = (angw_r & COS_MASK) + QUARTER_TURN;

  // duty = (2^30 + amp*cos + 2^14) >> 15, saturated
  assign duty_t = 34'sd1073741824 + 34'(prod_r[33:0]) + 34'sd16384;
  always_comb begin
    if (duty_t < 0) begin
      duty_v = '0;
    end else if (duty_t[33:31] != 3'd0) begin
      duty_v = 16'hFFFF;
    end else begin
      duty_v = duty_t[30:15];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (start) state_nxt = start_en ? S_RAMP : S_DONE;
      S_RAMP:  state_nxt = S_CLAMP;
      S_CLAMP: state_nxt = S_PHASE;
      S_PHASE: state_nxt = S_AMP;
      S_AMP:   state_nxt = S_ANGLE;
      S_ANGLE: state_nxt = S_FOLD;
      S_FOLD:  state_nxt = S_SQ;
      S_SQ:    state_nxt = S_X2;
      S_X2:    state_nxt = S_HMUL;
      S_HMUL:  state_nxt = S_HSUB;
      S_HSUB:  state_nxt = (k_r == 2'd3) ? S_FMUL : S_HMUL;
      S_FMUL:  state_nxt = S_COS;
      S_COS:   state_nxt = S_DMUL;
      S_DMUL:  state_nxt = S_DUTY;
      S_DUTY:  state_nxt = (ang_r == ANG_C) ? S_DONE : S_ANGLE;
      S_DONE:  if (ack) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and multiplier operands
  always_comb begin
    cur_nxt  = cur_r;
    acc_nxt  = acc_r;
    sum_nxt  = sum_r;
    jump_nxt = jump_r;
    up_nxt   = up_r;
    amp_nxt  = amp_r;
    ang_nxt  = ang_r;
    k_nxt    = k_r;
    angw_nxt = angw_r;
    quad_nxt = quad_r;
    x_nxt    = x_r;
    x2_nxt   = x2_r;
    p_nxt    = p_r;
    cos_nxt  = cos_r;
    res_nxt  = res_r;
    mul_a    = '0;
    mul_b    = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start && !start_en) begin
          res_nxt.duty_a      = '0;
          res_nxt.duty_b      = '0;
          res_nxt.duty_c      = '0;
          res_nxt.phase_angle = turn[31:16];
          res_nxt.ramping     = (cur_r != tgt);
        end
      end
      S_RAMP: begin
        up_nxt   = (tgt > cur_r);
        jump_nxt = (cfg.ramp_step == '0) || (cur_r == tgt);
        sum_nxt  = (tgt > cur_r) ? cur33 + step33 : cur33 - step33;
      end
      S_CLAMP: begin
        if (jump_r) begin
          cur_nxt = tgt;
        end else if (up_r) begin
          cur_nxt = (sum_r > tgt33) ? tgt : sum_r[31:0];
        end else begin
          cur_nxt = (sum_r < tgt33) ? tgt : sum_r[31:0];
        end
      end
      S_PHASE: begin
        acc_nxt = turn_sum[31 -: PHASE_BITS];
        mul_a   = 33'(signed'(cfg.vf_slope));
        mul_b   = cur33;
      end
      S_AMP: begin
        if (amp_sum > 34'sd32767) begin
          amp_nxt = 16'sh7FFF;
        end else if (amp_sum < -34'sd32768) begin
          amp_nxt = 16'sh8000;
        end else begin
          amp_nxt = amp_sum[15:0];
        end
        ang_nxt             = ANG_A;
        res_nxt.phase_angle = turn[31:16];
        res_nxt.ramping     = (cur_r != tgt);
      end
      S_ANGLE: begin
        unique case (ang_r)
          ANG_B:   angw_nxt = turn - THIRD_TURN;
          ANG_C:   angw_nxt = turn + THIRD_TURN;
          default: angw_nxt = turn;
        endcase
      end
      S_FOLD: begin
        quad_nxt = s_word[31:30];
        // odd quadrants mirror the quarter-wave argument
        x_nxt = s_word[30] ? Q30_ONE - {1'b0, s_word[29:0]} : {1'b0, s_word[29:0]};
      end
      S_SQ: begin
        mul_a = $signed({2'b00, x_r});
        mul_b = $signed({2'b00, x_r});
      end
      S_X2: begin
        x2_nxt = prod_r[60:30];
        p_nxt  = HORNER_SEED;
        k_nxt  = '0;
      end
      S_HMUL: begin
        mul_a = $signed({2'b00, p_r});
        mul_b = $signed({2'b00, x2_r});
      end
      S_HSUB: begin
        p_nxt = horner_coef(k_r) - prod_r[60:30];
        k_nxt = k_r + 2'd1;
      end
      S_FMUL: begin
        mul_a = $signed({2'b00, p_r});
        mul_b = $signed({2'b00, x_r});
      end
      S_COS: begin
        cos_nxt = quad_r[1] ? -$signed(r_mag) : $signed(r_mag);
      end
      S_DMUL: begin
        mul_a = 33'(amp_r);
        mul_b = 33'(cos_r);
      end
      S_DUTY: begin
        unique case (ang_r)
          ANG_B:   res_nxt.duty_b = duty_v;
          ANG_C:   res_nxt.duty_c = duty_v;
          default: res_nxt.duty_a = duty_v;
        endcase
        ang_nxt = ang_r + 2'd1;
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cur_r   <= '0;
      acc_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cur_r   <= cur_nxt;
      acc_r   <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r  <= sum_nxt;
    jump_r <= jump_nxt;
    up_r   <= up_nxt;
    amp_r  <= amp_nxt;
    ang_r  <= ang_nxt;
    k_r    <= k_nxt;
    angw_r <= angw_nxt;
    quad_r <= quad_nxt;
    x_r    <= x_nxt;
    x2_r   <= x2_nxt;
    p_r    <= p_nxt;
    cos_r  <= cos_nxt;
    res_r  <= res_nxt;
  end

  assign idle = (state_r == S_IDLE);
  assign done = (state_r == S_DONE);
  assign res  = res_r;

endmodule

### design/vfsd_checker.sv
// ----------------------------------------------------------------------------
// vfsd_checker
// Port-level checks of the duty generator, bound to the top level.
// ----------------------------------------------------------------------------
module vfsd_checker import vfsd_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_duty_a,
  input logic [15:0] out_duty_b,
  input logic [15:0] out_duty_c,
  input logic [15:0] out_phase_angle,
  input logic        out_ramping
);

  // an accepted tick makes the sequencer busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while previous tick in progress");

  // a new result only appears after the sequencer was working
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a tick in progress");

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_duty_a)
      && $stable(out_duty_b) && $stable(out_duty_c)
      && $stable(out_phase_angle) && $stable(out_ramping)))
    else $error("stalled result changed");

  // reset leaves the block empty and ready
  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !in_stall))
    else $error("block not idle after reset");

endmodule

bind vf_three_phase_sine_duty_generator vfsd_checker u_vfsd_checker (.*);

### test/tb_vf_three_phase_sine_duty_generator.sv
// ----------------------------------------------------------------------------
// tb_vf_three_phase_sine_duty_generator
// Self-checking bench for the V/f three-phase sine duty generator. A short
// stimulus table covers reset values, register extremes, jump and ramp with
// overshoot, and negative frequency. Random phases follow, each under new
// register settings and one of four patterns of sender gaps and receiver stalls.
// Results are checked against a bit-accurate duty predictor or fixed values.
// ----------------------------------------------------------------------------
module tb_vf_three_phase_sine_duty_generator;
  import vfsd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    bit           is_cfg;
    logic [1:0]   idx;
    logic [31:0]  wdata;
    logic         en;
    bit           typed;
    vfsd_result_t res;
  } script_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic        in_output_enable;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_duty_a;
  logic [15:0] out_duty_b;
  logic [15:0] out_duty_c;
  logic [15:0] out_phase_angle;
  logic        out_ramping;

  // predictor copy of registers and state
  logic signed [31:0] tgt_inc;
  logic        [30:0] ramp_inc;
  logic signed [31:0] slope_reg;
  logic signed [15:0] offset_reg;
  logic        [31:0] phase_acc;
  logic signed [31:0] cur_inc;

  vfsd_result_t pending_duties[$];
  script_row_t  script[$];
  idle_mode_t   idle_mode;
  int           mismatches;
  int           hold_left;
  bit           hold_req;

  vf_three_phase_sine_duty_generator uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_output_enable (in_output_enable),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_duty_a       (out_duty_a),
    .out_duty_b       (out_duty_b),
    .out_duty_c       (out_duty_c),
    .out_phase_angle  (out_phase_angle),
    .out_ramping      (out_ramping)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // cosine of a turn angle in Q1.15, range [-32768, 32768]
  function automatic int cos_q15(input logic [31:0] ang);
    logic [31:0] s;
    logic [63:0] f, x2, p, r;
    s = (ang & COS_MASK) + QUARTER_TURN;
    f = {34'd0, s[29:0]};
    if (s[30]) f = 64'h4000_0000 - f;
    x2 = (f * f) >> 30;
    p  = 64'd172272;
    p  = 64'd5026994 - ((p * x2) >> 30);
    p  = 64'd85569306 - ((p * x2) >> 30);
    p  = 64'd693598668 - ((p * x2) >> 30);
    p  = 64'd1686629713 - ((p * x2) >> 30);
    r  = (((p * f) >> 30) + 64'd16384) >> 15;
    if (r > 64'd32768) r = 64'd32768;
    return s[31] ? -int'(r) : int'(r);
  endfunction

  function automatic logic [15:0] duty_level(input longint amp, input logic [31:0] ang);
    longint t;
    t = 1073741824 + amp * cos_q15(ang) + 16384;
    if (t < 0) t = 0;
    t = t >>> 15;
    if (t > 65535) t = 65535;
    return t[15:0];
  endfunction

  // one control tick: ramp, advance phase, V/f amplitude, three duties; zero duties if disabled
  function automatic vfsd_result_t predict_duties(input logic en);
    vfsd_result_t r;
    longint tgt, cur, step, amp, slope_l, offset_l;
    logic [31:0] turn;
    tgt = tgt_inc;
    cur = cur_inc;
    step = ramp_inc;
    if (!en) begin
      turn = phase_acc << PHASE_SHIFT;
      r.duty_a = '0;
      r.duty_b = '0;
      r.duty_c = '0;
      r.phase_angle = turn[31:16];
      r.ramping = (cur != tgt);
      return r;
    end
    if (step == 0 || cur == tgt) begin
      cur = tgt;
    end else if (tgt > cur) begin
      cur = cur + step;
      if (cur > tgt) cur = tgt;
    end else begin
      cur = cur - step;
      if (cur < tgt) cur = tgt;
    end
    cur_inc = cur[31:0];
    turn = (phase_acc << PHASE_SHIFT) + cur_inc;
    phase_acc = turn >> PHASE_SHIFT;
    turn = phase_acc << PHASE_SHIFT;
    slope_l = slope_reg;
    offset_l = offset_reg;
    amp = offset_l + ((slope_l * cur) >>> 31);
    if (amp > 32767) amp = 32767;
    if (amp < -32768) amp = -32768;
    r.duty_a = duty_level(amp, turn);
    r.duty_b = duty_level(amp, turn - THIRD_TURN);
    r.duty_c = duty_level(amp, turn + THIRD_TURN);
    r.phase_angle = turn[31:16];
    r.ramping = (cur != tgt);
    return r;
  endfunction

  function automatic int send_idle_pct();
    case (idle_mode)
      IDLE_SENDER: return 61;
      IDLE_BOTH:   return 29;
      default:     return 0;
    endcase
  endfunction

  function automatic int recv_stall_pct();
    case (idle_mode)
      IDLE_RECEIVER: return 61;
      IDLE_BOTH:     return 29;
      default:       return 0;
    endcase
  endfunction

  function automatic void add_cfg(input logic [1:0] idx, input logic [31:0] data);
    script_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.wdata = data;
    script.push_back(row);
  endfunction

  function automatic void add_tick(input logic en, input bit typed, input vfsd_result_t res);
    script_row_t row;
    row = '0;
    row.en = en;
    row.typed = typed;
    row.res = res;
    script.push_back(row);
  endfunction

  // write lands on the next edge; cfg_we is lowered by the following tick
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_TARGET_INC: tgt_inc = data;
      REG_RAMP_STEP:  ramp_inc = data[30:0];
      REG_VF_SLOPE:   slope_reg = data;
      REG_VF_OFFSET:  offset_reg = data[15:0];
    endcase
    @(posedge clk);
  endtask

  task automatic send_tick(input logic en, input bit typed, input vfsd_result_t res);
    vfsd_result_t r;
    cfg_we <= 1'b0;
    in_valid <= 1'b1;
    in_output_enable <= en;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = predict_duties(en);
    pending_duties.push_back(typed ? res : r);
  endtask

  task automatic sender_pause();
    int n;
    n = 0;
    while ($urandom_range(99) < send_idle_pct()) n++;
    if (send_idle_pct() > 0 && $urandom_range(49) == 0) n = $urandom_range(70, 1);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = 400;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct());
    end
  end

  // result checker
  always @(posedge clk) begin
    vfsd_result_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got.duty_a = out_duty_a;
      got.duty_b = out_duty_b;
      got.duty_c = out_duty_c;
      got.phase_angle = out_phase_angle;
      got.ramping = out_ramping;
      if (pending_duties.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transaction: a=%h b=%h c=%h ph=%h rmp=%b",
                   got.duty_a, got.duty_b, got.duty_c, got.phase_angle, got.ramping);
      end else begin
        want = pending_duties.pop_front();
        if (got.duty_a !== want.duty_a || got.duty_b !== want.duty_b ||
            got.duty_c !== want.duty_c || got.phase_angle !== want.phase_angle ||
            got.ramping !== want.ramping) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp a=%h b=%h c=%h ph=%h rmp=%b  got a=%h b=%h c=%h ph=%h rmp=%b",
                     want.duty_a, want.duty_b, want.duty_c, want.phase_angle, want.ramping,
                     got.duty_a, got.duty_b, got.duty_c, got.phase_angle, got.ramping);
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    vfsd_result_t zero_res, mid_res, none;
    logic [31:0] w;
    int ph;
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_output_enable = 1'b0;
    out_stall = 1'b0;
    tgt_inc = '0;
    ramp_inc = '0;
    slope_reg = '0;
    offset_reg = '0;
    phase_acc = '0;
    cur_inc = '0;
    mismatches = 0;
    hold_left = 0;
    hold_req = 1'b0;
    idle_mode = IDLE_NONE;

    zero_res = '0;
    none = '0;
    mid_res = '0;
    mid_res.duty_a = 16'h8000;
    mid_res.duty_b = 16'h8000;
    mid_res.duty_c = 16'h8000;

    // reset values, then jump to the positive extremes
    add_tick(1'b0, 1'b1, zero_res);
    add_tick(1'b1, 1'b1, mid_res);
    add_cfg(REG_TARGET_INC, 32'h7FFF_FFFF);
    add_cfg(REG_RAMP_STEP,  32'h8000_0000);
    add_cfg(REG_VF_SLOPE,   32'h7FFF_FFFF);
    add_cfg(REG_VF_OFFSET,  32'h0000_7FFF);
    add_tick(1'b1, 1'b0, none);
    add_tick(1'b1, 1'b0, none);
    add_tick(1'b0, 1'b0, none);
    // full-size step down to the negative extreme, overshoot clamps
    add_cfg(REG_TARGET_INC, 32'h8000_0000);
    add_cfg(REG_RAMP_STEP,  32'hFFFF_FFFF);
    add_cfg(REG_VF_SLOPE,   32'h8000_0000);
    add_cfg(REG_VF_OFFSET,  32'hFFFF_8000);
    add_tick(1'b1, 1'b0, none);
    add_tick(1'b1, 1'b0, none);
    add_tick(1'b1, 1'b0, none);
    add_tick(1'b0, 1'b0, none);
    add_tick(1'b1, 1'b0, none);
    // small ramp up that overshoots, phase running backward
    add_cfg(REG_TARGET_INC, 32'h8000_09C4);
    add_cfg(REG_RAMP_STEP,  32'd1000);
    add_cfg(REG_VF_SLOPE,   32'hFFFF_FFFF);
    add_cfg(REG_VF_OFFSET,  32'h0000_0000);
    repeat (4) add_tick(1'b1, 1'b0, none);
    // most negative amplitude
    add_cfg(REG_TARGET_INC, 32'h0000_0000);
    add_cfg(REG_RAMP_STEP,  32'h0000_0000);
    add_cfg(REG_VF_SLOPE,   32'h0000_0000);
    add_cfg(REG_VF_OFFSET,  32'h0000_8000);
    add_tick(1'b1, 1'b0, none);
    add_tick(1'b0, 1'b0, none);
    // moderate frequency, ramp then steady
    add_cfg(REG_TARGET_INC, 32'h0040_0000);
    add_cfg(REG_RAMP_STEP,  32'h0010_0000);
    add_cfg(REG_VF_SLOPE,   32'h0000_1000);
    add_cfg(REG_VF_OFFSET,  32'h0000_4000);
    repeat (6) add_tick(1'b1, 1'b0, none);
    add_tick(1'b0, 1'b0, none);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        in_valid <= 1'b0;
        wait (pending_duties.size() == 0);
        write_reg(script[i].idx, script[i].wdata);
      end else begin
        send_tick(script[i].en, script[i].typed, script[i].res);
      end
    end
    in_valid <= 1'b0;
    wait (pending_duties.size() == 0);

    for (ph = 0; ph < 10; ph++) begin
      idle_mode = idle_mode_t'(ph % 4);
      case (ph)
        0: begin
          write_reg(REG_TARGET_INC, 32'h7FFF_FFFF);
          write_reg(REG_RAMP_STEP,  32'h7FFF_FFFF);
          write_reg(REG_VF_SLOPE,   32'h7FFF_FFFF);
          write_reg(REG_VF_OFFSET,  32'h0000_7FFF);
        end
        1: begin
          write_reg(REG_TARGET_INC, 32'h8000_0000);
          write_reg(REG_RAMP_STEP,  32'h8000_0000);
          write_reg(REG_VF_SLOPE,   32'h8000_0000);
          write_reg(REG_VF_OFFSET,  32'h0000_8000);
        end
        default: begin
          case ($urandom_range(4))
            0: w = 32'h7FFF_FFFF;
            1: w = 32'h8000_0000;
            2: w = '0;
            3: w = $urandom_range(32'h0020_0000) - 32'h0010_0000;
            default: w = $urandom;
          endcase
          write_reg(REG_TARGET_INC, w);
          case ($urandom_range(3))
            0: w = {1'($urandom_range(1)), 31'd0};
            1: w = 32'hFFFF_FFFF;
            2: w = {1'($urandom_range(1)), 31'd0} | $urandom_range(32'h0400_0000, 1);
            default: w = $urandom;
          endcase
          write_reg(REG_RAMP_STEP, w);
          case ($urandom_range(3))
            0: w = 32'h7FFF_FFFF;
            1: w = 32'h8000_0000;
            default: w = $urandom;
          endcase
          write_reg(REG_VF_SLOPE, w);
          w = $urandom;
          if ($urandom_range(3) == 0) w[15:0] = $urandom_range(1) ? 16'h7FFF : 16'h8000;
          write_reg(REG_VF_OFFSET, w);
        end
      endcase
      // long receiver hold-off so the block backs up into its input
      if (ph == 4) hold_req = 1'b1;
      for (int k = 0; k < 45; k++) begin
        send_tick($urandom_range(99) < 85, 1'b0, none);
        if (k == 44) in_valid <= 1'b0;
        else sender_pause();
      end
      wait (pending_duties.size() == 0);
    end

    repeat (60) @(posedge clk);
    if (mismatches == 0 && pending_duties.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### files.f
design/vfsd_pkg.sv
design/vfsd_mul.sv
design/vfsd_core.sv
design/vf_three_phase_sine_duty_generator.sv
design/vfsd_checker.sv
test/tb_vf_three_phase_sine_duty_generator.sv
